>>> design/assert_macros.svh
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed");

// Condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
    else $error("forbidden condition seen");

`endif

>>> design/i2f_pkg.sv
// Shared types and constants of the integer to floating-point converter.
package i2f_pkg;

  // Format geometry.
  localparam int unsigned INT_W    = 64;
  localparam int unsigned FRAC_D   = 52;
  localparam int unsigned FRAC_S   = 23;
  localparam int unsigned EXP_W_D  = 11;
  localparam int unsigned EXP_W_S  = 8;
  localparam int unsigned BIAS_D   = 1023;
  localparam int unsigned BIAS_S   = 127;
  localparam int unsigned MSB_TOP  = INT_W - 1;

  // Cycles from an accepted beat to its result strobe.
  localparam int unsigned PIPE_DEPTH = 6;

  // Configuration register indexes.
  localparam logic [1:0] CFG_ROUND_SINGLE = 2'd0;
  localparam logic [1:0] CFG_ROUND_DOUBLE = 2'd1;

  // Function field bits.
  localparam int unsigned FUNC_SIGNED = 0;
  localparam int unsigned FUNC_DOUBLE = 1;

  typedef enum logic [1:0] {
    RM_NEAREST   = 2'd0,
    RM_PLUS_INF  = 2'd1,
    RM_MINUS_INF = 2'd2,
    RM_TO_ZERO   = 2'd3
  } round_mode_e;

  // Per-item control that travels down the pipeline with the data.
  typedef struct packed {
    logic        neg;
    logic        dbl;
    round_mode_e mode;
  } i2f_ctl_t;

  // Leading zero count of a 16-bit chunk (value unused when the chunk is zero).
  function automatic logic [3:0] lzc16(input logic [15:0] x);
    logic [3:0] cnt;
    cnt = 4'd15;
    for (int i = 0; i < 16; i++) begin
      if (x[i]) begin
        cnt = 4'(15 - i);
      end
    end
    return cnt;
  endfunction

endpackage

>>> design/int64_to_float_convert.sv
// Pipelined 64-bit integer to IEEE-754 single or double precision converter.
// Throughput: one conversion per cycle; busy never rises, so the six register
// stages (negate, chunk scan, coarse shift, fine shift, round decision, round add)
// set the depth. Reset clears the stage valid bits and both rounding modes to
// nearest-even; the pipeline is empty and accepts a beat right after reset.
module int64_to_float_convert
  import i2f_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func_i,
  input  logic [63:0] int_value_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [1:0]  cfg_data_i,
  output logic        done_o,
  output logic [63:0] float_bits_o
);

  // Configuration registers.
  round_mode_e mode_single_q, mode_double_q;

  // Stage valid bits.
  logic [PIPE_DEPTH-1:0] valid_q, valid_d;

  // Stage 1: sign and magnitude.
  logic [63:0] s1_mag_q, s1_mag_d;
  i2f_ctl_t    s1_ctl_q, s1_ctl_d;

  // Stage 2: per-chunk leading zero scan.
  logic [63:0]     s2_mag_q;
  i2f_ctl_t        s2_ctl_q;
  logic [3:0]      s2_nz_q, s2_nz_d;
  logic [3:0][3:0] s2_lz_q, s2_lz_d;

  // Stage 3: coarse shift by whole chunks.
  logic [63:0] s3_mag_q, s3_mag_d;
  i2f_ctl_t    s3_ctl_q;
  logic [5:0]  s3_lzc_q, s3_lzc_d;
  logic        s3_zero_q, s3_zero_d;

  // Stage 4: fine shift and exponent.
  logic [63:0]         s4_norm_q, s4_norm_d;
  i2f_ctl_t            s4_ctl_q;
  logic [EXP_W_D-1:0]  s4_exp_q, s4_exp_d;
  logic                s4_zero_q;

  // Stage 5: significand and round decision.
  logic [FRAC_D:0]     s5_sig_q, s5_sig_d;
  logic                s5_up_q, s5_up_d;
  i2f_ctl_t            s5_ctl_q;
  logic [EXP_W_D-1:0]  s5_exp_q;
  logic                s5_zero_q;

  // Stage 6: output register.
  logic [63:0] float_q, float_d;

  logic accept;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;

  // Valid bits shift with the data.
  assign valid_d = {valid_q[PIPE_DEPTH-2:0], accept};

  // Stage 1: negate signed negatives and pick the rounding mode.
  always_comb begin
    s1_ctl_d.neg  = func_i[FUNC_SIGNED] && int_value_i[MSB_TOP];
    s1_ctl_d.dbl  = func_i[FUNC_DOUBLE];
    s1_ctl_d.mode = func_i[FUNC_DOUBLE] ? mode_double_q : mode_single_q;
    s1_mag_d      = s1_ctl_d.neg ? (64'd0 - int_value_i) : int_value_i;
  end

  // Stage 2: scan each 16-bit chunk independently.
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      s2_nz_d[c] = |s1_mag_q[c*16 +: 16];
      s2_lz_d[c] = lzc16(s1_mag_q[c*16 +: 16]);
    end
  end

  // Stage 3: pick the top nonzero chunk and shift it to the top.
  always_comb begin
    logic [1:0] top;
    logic [1:0] coarse;
    top = 2'd0;
    for (int c = 0; c < 4; c++) begin
      if (s2_nz_q[c]) begin
        top = 2'(c);
      end
    end
    coarse    = ~top;
    s3_mag_d  = s2_mag_q << {coarse, 4'b0000};
    s3_lzc_d  = {coarse, s2_lz_q[top]};
    s3_zero_d = ~|s2_nz_q;
  end

  // Stage 4: finish normalization and form the biased exponent.
  always_comb begin
    s4_norm_d = s3_mag_q << s3_lzc_q[3:0];
    s4_exp_d  = (s3_ctl_q.dbl ? EXP_W_D'(BIAS_D + MSB_TOP) : EXP_W_D'(BIAS_S + MSB_TOP))
                - EXP_W_D'(s3_lzc_q);
  end

  // Stage 5: split significand, guard and sticky; decide to round up.
  always_comb begin
    logic g, s, lsb, inexact;
    if (s4_ctl_q.dbl) begin
      s5_sig_d = s4_norm_q[63 -: FRAC_D+1];
      lsb      = s4_norm_q[63-FRAC_D];
      g        = s4_norm_q[62-FRAC_D];
      s        = |s4_norm_q[61-FRAC_D:0];
    end else begin
      s5_sig_d = (FRAC_D+1)'(s4_norm_q[63 -: FRAC_S+1]);
      lsb      = s4_norm_q[63-FRAC_S];
      g        = s4_norm_q[62-FRAC_S];
      s        = |s4_norm_q[61-FRAC_S:0];
    end
    inexact = g || s;
    case (s4_ctl_q.mode)
      RM_NEAREST:   s5_up_d = g && (s || lsb);
      RM_PLUS_INF:  s5_up_d = !s4_ctl_q.neg && inexact;
      RM_MINUS_INF: s5_up_d = s4_ctl_q.neg && inexact;
      RM_TO_ZERO:   s5_up_d = 1'b0;
      default:      s5_up_d = 1'b0;
    endcase
  end

  // Stage 6: round add, carry renormalize and pack the result.
  always_comb begin
    logic [FRAC_D+1:0]  sum;
    logic               carry;
    logic [EXP_W_D-1:0] exp;
    sum   = {1'b0, s5_sig_q} + (FRAC_D+2)'(s5_up_q);
    carry = s5_ctl_q.dbl ? sum[FRAC_D+1] : sum[FRAC_S+1];
    exp   = s5_exp_q + EXP_W_D'(carry);
    if (s5_zero_q) begin
      float_d = 64'd0;
    end else if (s5_ctl_q.dbl) begin
      float_d = {s5_ctl_q.neg, exp, sum[FRAC_D-1:0]};
    end else begin
      float_d = {32'd0, s5_ctl_q.neg, exp[EXP_W_S-1:0], sum[FRAC_S-1:0]};
    end
  end

  // Control state: valid bits and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q       <= '0;
      mode_single_q <= RM_NEAREST;
      mode_double_q <= RM_NEAREST;
    end else begin
      valid_q <= valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_ROUND_SINGLE: mode_single_q <= round_mode_e'(cfg_data_i);
          CFG_ROUND_DOUBLE: mode_double_q <= round_mode_e'(cfg_data_i);
          default: ;
        endcase
      end
    end
  end

  // Payload registers of all stages.
  always_ff @(posedge clk_i) begin
    s1_mag_q  <= s1_mag_d;
    s1_ctl_q  <= s1_ctl_d;
    s2_mag_q  <= s1_mag_q;
    s2_ctl_q  <= s1_ctl_q;
    s2_nz_q   <= s2_nz_d;
    s2_lz_q   <= s2_lz_d;
    s3_mag_q  <= s3_mag_d;
    s3_ctl_q  <= s2_ctl_q;
    s3_lzc_q  <= s3_lzc_d;
    s3_zero_q <= s3_zero_d;
    s4_norm_q <= s4_norm_d;
    s4_ctl_q  <= s3_ctl_q;
    s4_exp_q  <= s4_exp_d;
    s4_zero_q <= s3_zero_q;
    s5_sig_q  <= s5_sig_d;
    s5_up_q   <= s5_up_d;
    s5_ctl_q  <= s4_ctl_q;
    s5_exp_q  <= s4_exp_q;
    s5_zero_q <= s4_zero_q;
    float_q   <= float_d;
  end

  assign done_o       = valid_q[PIPE_DEPTH-1];
  assign float_bits_o = float_q;

endmodule

>>> design/i2f_checker.sv
// Port-level assertions for the converter and the bind that attaches them.
`include "assert_macros.svh"

module i2f_checker
  import i2f_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic [1:0]  func_i,
  input logic [63:0] int_value_i,
  input logic        done_o,
  input logic [63:0] float_bits_o
);

  // Every accepted beat yields a strobe a fixed number of cycles later.
  `ASSERT_ALWAYS(a_start_to_done, clk_i, rst_ni, (start && !busy) |-> ##PIPE_DEPTH done_o)

  // No strobe without a beat accepted that many cycles before.
  `ASSERT_ALWAYS(a_done_has_start, clk_i, rst_ni, done_o |-> $past(start && !busy, PIPE_DEPTH))

  // A single precision result keeps its upper word clear.
  `ASSERT_ALWAYS(a_single_upper_zero, clk_i, rst_ni, (done_o && !$past(func_i[FUNC_DOUBLE], PIPE_DEPTH)) |-> (float_bits_o[63:32] == 32'd0))

  // A zero operand converts to positive zero.
  `ASSERT_ALWAYS(a_zero_in_zero_out, clk_i, rst_ni, (done_o && ($past(int_value_i, PIPE_DEPTH) == 64'd0)) |-> (float_bits_o == 64'd0))

  // The pipeline never pushes back on start.
  `ASSERT_NEVER(a_never_busy, clk_i, rst_ni, busy)

endmodule

bind int64_to_float_convert i2f_checker u_i2f_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .func_i       (func_i),
  .int_value_i  (int_value_i),
  .done_o       (done_o),
  .float_bits_o (float_bits_o)
);

>>> verif/int64_to_float_convert_test.sv
// Self-checking testbench for the pipelined 64-bit integer to float converter.
module int64_to_float_convert_test;
  import i2f_pkg::*;

  // Function field codes: signedness in bit 0, double precision in bit 1.
  localparam logic [1:0] FN_U_SINGLE = 2'b00;
  localparam logic [1:0] FN_S_SINGLE = 2'b01;
  localparam logic [1:0] FN_U_DOUBLE = 2'b10;
  localparam logic [1:0] FN_S_DOUBLE = 2'b11;

  // Register indexes that the block does not implement.
  localparam logic [1:0] CFG_UNUSED_LO = 2'd2;
  localparam logic [1:0] CFG_UNUSED_HI = 2'd3;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned MAX_REPORTS    = 10;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        start       = 1'b0;
  logic        busy;
  logic [1:0]  func_i      = FN_U_SINGLE;
  logic [63:0] int_value_i = 64'd0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = CFG_ROUND_SINGLE;
  logic [1:0]  cfg_data_i  = RM_NEAREST;
  logic        done_o;
  logic [63:0] float_bits_o;

  // Local copy of the rounding registers and the results still owed.
  round_mode_e mode_single = RM_NEAREST;
  round_mode_e mode_double = RM_NEAREST;
  logic [63:0] pending_floats[$];

  int unsigned conversions_sent    = 0;
  int unsigned results_checked     = 0;
  int unsigned mismatch_count      = 0;
  int unsigned cfg_writes          = 0;
  int unsigned unused_index_writes = 0;
  int unsigned quiet_cycles        = 0;
  int unsigned gap_odds            = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  int64_to_float_convert dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .func_i      (func_i),
    .int_value_i (int_value_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .done_o      (done_o),
    .float_bits_o(float_bits_o)
  );

  // Expected IEEE-754 bits for one operand under the current rounding registers.
  function automatic logic [63:0] int_to_float_bits(input logic [1:0] f, input logic [63:0] v);
    logic        neg;
    logic        dbl;
    logic        up;
    logic [63:0] mag;
    logic [63:0] sig;
    logic [63:0] expo;
    logic [63:0] unit;
    logic [63:0] rem;
    logic [63:0] half;
    logic [63:0] bits;
    int unsigned fb;
    int unsigned msb;
    int unsigned d;
    round_mode_e mode;
    dbl  = f[FUNC_DOUBLE];
    neg  = f[FUNC_SIGNED] & v[63];
    mag  = neg ? (64'd0 - v) : v;
    fb   = dbl ? FRAC_D : FRAC_S;
    mode = dbl ? mode_double : mode_single;
    if (mag == 64'd0) begin
      return 64'd0;
    end
    msb = 0;
    for (int i = 0; i < 64; i++) begin
      if (mag[i]) begin
        msb = i;
      end
    end
    expo = 64'(msb + (dbl ? BIAS_D : BIAS_S));
    up   = 1'b0;
    if (msb <= fb) begin
      sig = mag << (fb - msb);
    end else begin
      // Drop the bits below the fraction, then decide on the increment.
      d    = msb - fb;
      unit = 64'd1 << d;
      rem  = mag & (unit - 64'd1);
      half = unit >> 1;
      sig  = mag >> d;
      case (mode)
        RM_NEAREST:   up = (rem > half) || ((rem == half) && sig[0]);
        RM_PLUS_INF:  up = !neg && (rem != 64'd0);
        RM_MINUS_INF: up = neg && (rem != 64'd0);
        default:      up = 1'b0;
      endcase
      sig = sig + 64'(up);
      // A carry out of the significand renormalizes it.
      if ((sig >> (fb + 1)) != 64'd0) begin
        sig  = sig >> 1;
        expo = expo + 64'd1;
      end
    end
    bits = (sig & ((64'd1 << fb) - 64'd1)) | (expo << fb);
    if (neg) begin
      bits[dbl ? 63 : 31] = 1'b1;
    end
    if (!dbl) begin
      bits[63:32] = '0;
    end
    return bits;
  endfunction

  // Operands biased toward rounding boundaries, small magnitudes and extremes.
  function automatic logic [63:0] random_operand();
    logic [63:0] r;
    logic [63:0] low;
    logic [63:0] v;
    int unsigned fb;
    int unsigned top;
    int unsigned d;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0, 1: v = r;
      2: v = r >> $urandom_range(0, 63);
      3: begin
        fb  = $urandom_range(0, 1) ? FRAC_D : FRAC_S;
        top = $urandom_range(fb + 1, 63);
        d   = top - fb;
        case ($urandom_range(0, 5))
          0: low = 64'd1 << (d - 1);
          1: low = (64'd1 << (d - 1)) - 64'd1;
          2: low = (64'd1 << (d - 1)) + 64'd1;
          3: low = (64'd1 << d) - 64'd1;
          4: low = 64'd0;
          default: low = 64'd1;
        endcase
        low = low & ((64'd1 << d) - 64'd1);
        v = (64'd1 << top) | (r & ((64'd1 << top) - 64'd1) & ~((64'd1 << d) - 64'd1)) | low;
        if ($urandom_range(0, 1)) begin
          v = 64'd0 - v;
        end
      end
      4: v = 64'd0 - (r >> $urandom_range(0, 63));
      default: v = $urandom_range(0, 1) ? ({1'b1, 63'd0} ^ (r & 64'hff))
                                        : ({64{1'b1}} ^ (r & 64'hff));
    endcase
    return v;
  endfunction

  function automatic void note_failure(input string what, input logic [63:0] want,
                                       input logic [63:0] got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("mismatch: %s expected %h got %h", what, want, got);
    end
  endfunction

  // Sample every handshake at the edge that completes it.
  always @(posedge clk_i) begin : monitor
    logic busy_edge;
    busy_edge = 1'b0;
    if (rst_ni) begin
      if (done_o) begin
        busy_edge = 1'b1;
        results_checked++;
        if (pending_floats.size() == 0) begin
          note_failure("float_bits with no conversion pending", 64'd0, float_bits_o);
        end else begin
          if (float_bits_o !== pending_floats[0]) begin
            note_failure("float_bits", pending_floats[0], float_bits_o);
          end
          void'(pending_floats.pop_front());
        end
      end
      if (start && !busy) begin
        busy_edge = 1'b1;
        pending_floats.push_back(int_to_float_bits(func_i, int_value_i));
      end
      if (cfg_valid_i && cfg_ready_o) begin
        busy_edge = 1'b1;
        cfg_writes++;
        case (cfg_index_i)
          CFG_ROUND_SINGLE: mode_single = round_mode_e'(cfg_data_i);
          CFG_ROUND_DOUBLE: mode_double = round_mode_e'(cfg_data_i);
          default:          unused_index_writes++;
        endcase
      end
      quiet_cycles = busy_edge ? 0 : quiet_cycles + 1;
    end
  end

  // Stop a hung run.
  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
    end
    $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  // Present one operand, hold it until accepted, then maybe idle for a burst.
  task automatic send_conversion(input logic [1:0] f, input logic [63:0] v);
    start       <= 1'b1;
    func_i      <= f;
    int_value_i <= v;
    conversions_sent++;
    do @(posedge clk_i); while (busy);
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      start       <= 1'b0;
      func_i      <= 2'($urandom);
      int_value_i <= {$urandom, $urandom};
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
  endtask

  // Stop sending and wait for every owed result.
  task automatic drain_pipeline();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_floats.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_random_batch(input int unsigned count);
    for (int unsigned n = 0; n < count; n++) begin
      send_conversion(2'($urandom_range(0, 3)), random_operand());
    end
    drain_pipeline();
  endtask

  // Zero, the integer extremes, exact values, ties and carries at reset rounding.
  task automatic test_directed_extremes();
    gap_odds = 3;
    send_conversion(FN_U_SINGLE, 64'd0);
    send_conversion(FN_S_DOUBLE, 64'd0);
    send_conversion(FN_U_DOUBLE, 64'd1);
    send_conversion(FN_S_SINGLE, {64{1'b1}});
    send_conversion(FN_U_DOUBLE, {64{1'b1}});
    send_conversion(FN_U_SINGLE, {64{1'b1}});
    send_conversion(FN_S_DOUBLE, {1'b1, 63'd0});
    send_conversion(FN_S_SINGLE, {1'b1, 63'd0});
    send_conversion(FN_U_DOUBLE, {1'b1, 63'd0});
    send_conversion(FN_S_DOUBLE, {1'b0, {63{1'b1}}});
    send_conversion(FN_U_SINGLE, (64'd1 << 24) + 64'd1);
    send_conversion(FN_U_SINGLE, (64'd1 << 24) + 64'd3);
    send_conversion(FN_U_DOUBLE, (64'd1 << 53) + 64'd1);
    send_conversion(FN_S_DOUBLE, (64'd1 << 53) + 64'd3);
    send_conversion(FN_S_SINGLE, 64'd0 - ((64'd1 << 24) + 64'd3));
    send_conversion(FN_S_DOUBLE, 64'd0 - ((64'd1 << 53) + 64'd1));
    send_conversion(FN_U_SINGLE, 64'h0000_0000_00ff_ffff);
    send_conversion(FN_U_SINGLE, 64'h0000_0000_1fff_ffff);
    send_conversion(FN_S_DOUBLE, 64'd1 << 40);
    send_conversion(FN_U_DOUBLE, 64'h00ff_ffff_ffff_ffff);
    send_conversion(FN_S_SINGLE, 64'd0 - 64'd1);
    drain_pipeline();
  endtask

  // Random operands under several pairs of rounding modes, extremes included.
  task automatic test_rounding_modes();
    round_mode_e single_list[6];
    round_mode_e double_list[6];
    single_list = '{RM_PLUS_INF, RM_MINUS_INF, RM_TO_ZERO, RM_NEAREST, RM_PLUS_INF, RM_MINUS_INF};
    double_list = '{RM_MINUS_INF, RM_PLUS_INF, RM_TO_ZERO, RM_TO_ZERO, RM_PLUS_INF, RM_MINUS_INF};
    for (int k = 0; k < 6; k++) begin
      write_register(CFG_ROUND_SINGLE, single_list[k]);
      write_register(CFG_ROUND_DOUBLE, double_list[k]);
      gap_odds = (k == 2) ? 0 : $urandom_range(2, 6);
      send_random_batch(110);
    end
  endtask

  // Writes to unimplemented indexes must leave both rounding modes alone.
  task automatic test_unused_indexes();
    write_register(CFG_ROUND_SINGLE, RM_TO_ZERO);
    write_register(CFG_ROUND_DOUBLE, RM_PLUS_INF);
    write_register(CFG_UNUSED_LO, 2'($urandom));
    write_register(CFG_UNUSED_HI, 2'($urandom));
    gap_odds = 4;
    send_random_batch(80);
  endtask

  // Closing stretch at full rate back at the reset rounding modes.
  task automatic test_full_rate();
    write_register(CFG_ROUND_SINGLE, RM_NEAREST);
    write_register(CFG_ROUND_DOUBLE, RM_NEAREST);
    gap_odds = 0;
    send_random_batch(100);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_extremes();
    test_rounding_modes();
    test_unused_indexes();
    test_full_rate();
    repeat (PIPE_DEPTH + 4) @(posedge clk_i);
    $display("Covered %0d conversions over all func codes and rounding modes, %0d checked.",
             conversions_sent, results_checked);
    $display("Register writes: %0d, of which %0d went to unused indexes; %0d mismatches.",
             cfg_writes, unused_index_writes, mismatch_count);
    if (pending_floats.size() != 0) begin
      $display("%0d results never arrived", pending_floats.size());
    end
    if (mismatch_count == 0 && pending_floats.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+design
design/i2f_pkg.sv
design/int64_to_float_convert.sv
design/i2f_checker.sv
verif/int64_to_float_convert_test.sv
